FILE: hw/rtl/vpa_pkg.sv
// Shared types, codes and defaults of the variable partition allocator.
`default_nettype none
package vpa_pkg;

  localparam int ADDR_W  = 16;
  localparam int SIZE_W  = 17;
  localparam int OWNER_W = 16;

  localparam int DEF_MEM_BYTES  = 65536;
  localparam int DEF_PAGE_BYTES = 256;
  localparam int DEF_MAX_BLOCKS = 64;

  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic [1:0] REG_FIT_POLICY = 2'd0;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_NOOWNER = 3'd2,
    ST_BAD     = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef struct packed {
    logic               mode;
    logic [OWNER_W-1:0] owner_id;
    logic [SIZE_W-1:0]  request_bytes;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] start_address;
    logic [SIZE_W-1:0] free_bytes;
  } out_t;

  typedef struct packed {
    logic               busy;
    logic [OWNER_W-1:0] owner;
    logic [SIZE_W-1:0]  size;
    logic [ADDR_W-1:0]  start;
  } entry_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_DIV,
    S_CHK,
    S_RD,
    S_EV,
    S_ALLOC_DEC,
    S_INS_RD,
    S_INS_WR,
    S_SPLIT_WR,
    S_PICK_WR,
    S_FREE_DEC,
    S_NXT_RD,
    S_NXT_EV,
    S_MERGE,
    S_DEL_CHK,
    S_DEL_RD,
    S_DEL_WR,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/variable_partition_allocator_top.sv
// Variable partition allocator: block table in memory, scanned and edited in place.
//
// Input channel in_valid/in_stall/in_data carries one request beat: allocate
// (mode 0) request_bytes for owner_id, or free the first block of owner_id.
// Output channel out_valid/out_stall/out_data returns exactly one result beat
// per request: status, start address of an allocated block and free total.
// The user must write fit_policy over the APB port (address 0) only while the block
// is idle; the block itself does not enforce this. One request is handled at a time.
// An allocate does a page check, then reads and evaluates table entries in turn,
// moves entries up when it splits a block, and writes the split remainder and the
// picked entry. A free scans for the owner's block, reads the entry after it if
// there is one, merges, and moves later entries down when blocks merge. The block
// table memory has a single read port and is read one entry at a time through a
// registered read. After reset the block writes the initial free block into entry 0
// and then accepts requests. A result waiting under out_stall is held in the output
// register; the next request is accepted and worked on, and its result waits until
// the previous beat has been taken.
`default_nettype none
module variable_partition_allocator_top #(
  parameter int MEM_BYTES  = vpa_pkg::DEF_MEM_BYTES,
  parameter int PAGE_BYTES = vpa_pkg::DEF_PAGE_BYTES,
  parameter int MAX_BLOCKS = vpa_pkg::DEF_MAX_BLOCKS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire vpa_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output vpa_pkg::out_t     out_data,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [1:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import vpa_pkg::*;

  localparam int IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  // reciprocal of the page size, exact for every SIZE_W-bit request
  localparam int PG_L    = $clog2(PAGE_BYTES);
  localparam int SHIFT   = SIZE_W + PG_L;
  localparam int RECIP_W = SIZE_W + 2;
  localparam int PROD_W  = SHIFT + SIZE_W;
  localparam longint RECIP_L = ((longint'(1) <<< SHIFT) + longint'(PAGE_BYTES) - longint'(1))
                               / longint'(PAGE_BYTES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  state_t state, state_next;

  // block table memory
  entry_t mem [MAX_BLOCKS];
  entry_t rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata;

  logic [1:0]         policy;
  logic               cur_mode;
  logic [OWNER_W-1:0] cur_owner;
  logic [SIZE_W-1:0]  cur_req;
  logic [CNT_W-1:0]   count, idx, pick, ins_i, del_dst, del_src;
  logic [1:0]         del_n;
  logic               found;
  logic [ADDR_W-1:0]  pick_start, prev_start;
  logic [SIZE_W-1:0]  pick_size, prev_size, next_size, free_total;
  logic               prev_free, next_free;
  logic [SIZE_W-1:0]  quot;
  status_t            res_status;
  logic [ADDR_W-1:0]  res_addr;

  logic              fits, hit, is_last, early, scan_stop, bad_alloc, prev_ok, out_free;
  logic [PROD_W-1:0] recip_prod;
  logic [SIZE_W-1:0] page_back;
  logic [SIZE_W-1:0] merged_mid;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {30'd0, policy};
  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= 2'd0;
    end else if (psel && penable && pwrite && paddr == REG_FIT_POLICY) begin
      policy <= pwdata[1:0];
    end
  end

  // memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // scan evaluation and page check by reciprocal multiply
  always_comb begin
    fits      = !rdata.busy && rdata.size >= cur_req;
    hit       = rdata.busy && rdata.owner == cur_owner;
    is_last   = idx == count - CNT_W'(1);
    early     = cur_mode ? hit
                         : (fits && !found && policy != POL_BEST && policy != POL_WORST);
    scan_stop = is_last || early;
    recip_prod = PROD_W'(cur_req) * PROD_W'(RECIP);
    page_back  = SIZE_W'(quot * SIZE_W'(PAGE_BYTES));
    bad_alloc  = cur_owner == '0 || cur_req == '0 ||
                 cur_req > SIZE_W'(MEM_BYTES) || page_back != cur_req;
    prev_ok    = pick != '0 && prev_free;
    merged_mid = pick_size + (next_free ? next_size : '0);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_INIT: state_next = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          if (!in_data.mode) state_next = S_DIV;
          else if (in_data.owner_id == '0) state_next = S_DONE;
          else state_next = S_RD;
        end
      end
      S_DIV: state_next = S_CHK;
      S_CHK: state_next = bad_alloc ? S_DONE : S_RD;
      S_RD: state_next = S_EV;
      S_EV: begin
        if (!scan_stop) state_next = S_RD;
        else if (cur_mode) state_next = hit ? S_FREE_DEC : S_DONE;
        else state_next = (found || fits) ? S_ALLOC_DEC : S_DONE;
      end
      S_ALLOC_DEC: begin
        if (pick_size == cur_req) state_next = S_PICK_WR;
        else if (count == CNT_W'(MAX_BLOCKS)) state_next = S_DONE;
        else if (count > pick + CNT_W'(1)) state_next = S_INS_RD;
        else state_next = S_SPLIT_WR;
      end
      S_INS_RD: state_next = S_INS_WR;
      S_INS_WR: state_next = (ins_i - CNT_W'(1) > pick + CNT_W'(1)) ? S_INS_RD : S_SPLIT_WR;
      S_SPLIT_WR: state_next = S_PICK_WR;
      S_PICK_WR: state_next = S_DONE;
      S_FREE_DEC: state_next = (pick + CNT_W'(1) < count) ? S_NXT_RD : S_MERGE;
      S_NXT_RD: state_next = S_NXT_EV;
      S_NXT_EV: state_next = S_MERGE;
      S_MERGE: state_next = S_DEL_CHK;
      S_DEL_CHK: state_next = (del_n != 2'd0 && del_src < count) ? S_DEL_RD : S_DONE;
      S_DEL_RD: state_next = S_DEL_WR;
      S_DEL_WR: state_next = S_DEL_CHK;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory accesses per state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    case (state)
      S_INIT: begin
        mem_we         = 1'b1;
        mem_wdata.size = SIZE_W'(MEM_BYTES);
      end
      S_RD:     mem_raddr = idx[IDX_W-1:0];
      S_INS_RD: mem_raddr = IDX_W'(ins_i - CNT_W'(1));
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ins_i[IDX_W-1:0];
        mem_wdata = rdata;
      end
      S_SPLIT_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = IDX_W'(pick + CNT_W'(1));
        mem_wdata.start = pick_start + cur_req[ADDR_W-1:0];
        mem_wdata.size  = pick_size - cur_req;
      end
      S_PICK_WR: begin
        mem_we          = 1'b1;
        mem_waddr       = pick[IDX_W-1:0];
        mem_wdata.busy  = 1'b1;
        mem_wdata.owner = cur_owner;
        mem_wdata.size  = cur_req;
        mem_wdata.start = pick_start;
      end
      S_NXT_RD: mem_raddr = IDX_W'(pick + CNT_W'(1));
      S_MERGE: begin
        mem_we = 1'b1;
        if (prev_ok) begin
          mem_waddr       = IDX_W'(pick - CNT_W'(1));
          mem_wdata.start = prev_start;
          mem_wdata.size  = prev_size + merged_mid;
        end else begin
          mem_waddr       = pick[IDX_W-1:0];
          mem_wdata.start = pick_start;
          mem_wdata.size  = merged_mid;
        end
      end
      S_DEL_RD: mem_raddr = del_src[IDX_W-1:0];
      S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = del_dst[IDX_W-1:0];
        mem_wdata = rdata;
      end
      default: ;
    endcase
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      count      <= CNT_W'(1);
      free_total <= SIZE_W'(MEM_BYTES);
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          cur_mode   <= in_data.mode;
          cur_owner  <= in_data.owner_id;
          cur_req    <= in_data.request_bytes;
          idx        <= '0;
          found      <= 1'b0;
          prev_free  <= 1'b0;
          res_status <= ST_BAD;
          res_addr   <= '0;
        end
        S_DIV: quot <= recip_prod[SHIFT +: SIZE_W];
        S_EV: begin
          if (!scan_stop) idx <= idx + CNT_W'(1);
          if (cur_mode) begin
            if (hit) begin
              pick       <= idx;
              pick_start <= rdata.start;
              pick_size  <= rdata.size;
            end else begin
              prev_free  <= !rdata.busy;
              prev_start <= rdata.start;
              prev_size  <= rdata.size;
            end
            if (scan_stop && !hit) res_status <= ST_NOOWNER;
          end else begin
            if (fits && (!found ||
                         (policy == POL_BEST && rdata.size < pick_size) ||
                         (policy == POL_WORST && rdata.size > pick_size))) begin
              pick       <= idx;
              pick_start <= rdata.start;
              pick_size  <= rdata.size;
              found      <= 1'b1;
            end
            if (scan_stop && !found && !fits) res_status <= ST_NOFIT;
          end
        end
        S_ALLOC_DEC: begin
          ins_i <= count;
          if (pick_size != cur_req && count == CNT_W'(MAX_BLOCKS)) res_status <= ST_FULL;
        end
        S_INS_WR: ins_i <= ins_i - CNT_W'(1);
        S_SPLIT_WR: count <= count + CNT_W'(1);
        S_PICK_WR: begin
          free_total <= free_total - cur_req;
          res_status <= ST_OK;
          res_addr   <= pick_start;
        end
        S_FREE_DEC: next_free <= 1'b0;
        S_NXT_EV: begin
          next_free <= !rdata.busy;
          next_size <= rdata.size;
        end
        S_MERGE: begin
          free_total <= free_total + pick_size;
          res_status <= ST_OK;
          if (prev_ok) begin
            del_dst <= pick;
            del_src <= pick + CNT_W'(1) + CNT_W'(next_free);
            del_n   <= 2'd1 + 2'(next_free);
          end else begin
            del_dst <= pick + CNT_W'(1);
            del_src <= pick + CNT_W'(1) + CNT_W'(next_free);
            del_n   <= 2'(next_free);
          end
        end
        S_DEL_CHK: begin
          if (!(del_n != 2'd0 && del_src < count)) begin
            count <= count - CNT_W'(del_n);
            del_n <= 2'd0;
          end
        end
        S_DEL_WR: begin
          del_dst <= del_dst + CNT_W'(1);
          del_src <= del_src + CNT_W'(1);
        end
        S_DONE: begin
          if (out_free) begin
            out_valid              <= 1'b1;
            out_data.status        <= res_status;
            out_data.start_address <= res_addr;
            out_data.free_bytes    <= free_total;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: verif/variable_partition_allocator_top_tb.sv
// Self-checking testbench of the variable partition allocator, with a table predictor.
`timescale 1ns / 100ps
`default_nettype none
module variable_partition_allocator_top_tb;
  import vpa_pkg::*;

  localparam int MEM   = DEF_MEM_BYTES;
  localparam int PAGE  = DEF_PAGE_BYTES;
  localparam int NBLK  = DEF_MAX_BLOCKS;
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;
  localparam logic [1:0] POL_FIRST  = 2'd0;
  localparam logic [1:0] POL_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  variable_partition_allocator_top DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the block table
  int unsigned tbl_start[NBLK], tbl_size[NBLK], tbl_owner[NBLK];
  bit tbl_busy[NBLK];
  int unsigned tbl_count, free_sum;
  logic [1:0] policy;

  in_t  request_q[$];
  out_t result_q[$];
  int errors = 0, sent = 0, got = 0, ok_cnt = 0, full_cnt = 0, nofit_cnt = 0;

  function automatic void table_reset();
    for (int i = 0; i < NBLK; i++) begin
      tbl_start[i] = 0; tbl_size[i] = 0; tbl_owner[i] = 0; tbl_busy[i] = 0;
    end
    tbl_size[0] = MEM;
    tbl_count = 1;
    free_sum = MEM;
  endfunction

  function automatic void drop_entry(int unsigned k);
    for (int unsigned i = k; i + 1 < tbl_count; i++) begin
      tbl_start[i] = tbl_start[i+1]; tbl_size[i] = tbl_size[i+1];
      tbl_owner[i] = tbl_owner[i+1]; tbl_busy[i] = tbl_busy[i+1];
    end
    tbl_count--;
    tbl_start[tbl_count] = 0; tbl_size[tbl_count] = 0;
    tbl_owner[tbl_count] = 0; tbl_busy[tbl_count] = 0;
  endfunction

  // Work out the result of one request and update the table
  function automatic out_t allocate_or_free(in_t r);
    out_t o;
    status_t st;
    int unsigned pick, k, addr;
    bit found;
    int unsigned ow, rq;
    ow = r.owner_id; rq = r.request_bytes; addr = 0; pick = 0; found = 0;
    st = ST_OK;
    if (r.mode == MODE_ALLOC) begin
      if (ow == 0 || rq == 0 || rq > MEM || (rq % PAGE) != 0) st = ST_BAD;
      else begin
        for (int unsigned i = 0; i < tbl_count; i++) begin
          if (tbl_busy[i] || tbl_size[i] < rq) continue;
          if (!found) begin
            pick = i; found = 1;
            if (policy != POL_BEST && policy != POL_WORST) break;
          end else if (policy == POL_BEST && tbl_size[i] < tbl_size[pick]) pick = i;
          else if (policy == POL_WORST && tbl_size[i] > tbl_size[pick]) pick = i;
        end
        if (!found) st = ST_NOFIT;
        else if (tbl_size[pick] > rq && tbl_count >= NBLK) st = ST_FULL;
        else begin
          if (tbl_size[pick] > rq) begin
            for (int unsigned i = tbl_count; i > pick; i--) begin
              tbl_start[i] = tbl_start[i-1]; tbl_size[i] = tbl_size[i-1];
              tbl_owner[i] = tbl_owner[i-1]; tbl_busy[i] = tbl_busy[i-1];
            end
            tbl_count++;
            tbl_size[pick] = rq;
            tbl_start[pick+1] = tbl_start[pick] + rq;
            tbl_size[pick+1] -= rq;
          end
          tbl_owner[pick] = ow; tbl_busy[pick] = 1;
          free_sum -= tbl_size[pick];
          addr = tbl_start[pick];
        end
      end
    end else begin
      if (ow == 0) st = ST_BAD;
      else begin
        for (k = 0; k < tbl_count; k++)
          if (tbl_busy[k] && tbl_owner[k] == ow) break;
        if (k >= tbl_count) st = ST_NOOWNER;
        else begin
          free_sum += tbl_size[k];
          tbl_busy[k] = 0; tbl_owner[k] = 0;
          if (k + 1 < tbl_count && !tbl_busy[k+1]) begin
            tbl_size[k] += tbl_size[k+1];
            drop_entry(k + 1);
          end
          if (k > 0 && !tbl_busy[k-1]) begin
            tbl_size[k-1] += tbl_size[k];
            drop_entry(k);
          end
        end
      end
    end
    o.status = st;
    o.start_address = (st == ST_OK) ? addr[15:0] : '0;
    o.free_bytes = free_sum[16:0];
    return o;
  endfunction

  // Driver: present queued beats with random gaps
  int gap_in = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        result_q.push_back(allocate_or_free(in_data));
        sent++;
        if (request_q.size() > 0 && gap_in == 0 && $urandom_range(0, 3) != 0) begin
          in_data <= request_q.pop_front();
        end else begin
          in_valid <= 1'b0;
          gap_in <= $urandom_range(0, 19);
        end
      end else if (!in_valid && request_q.size() > 0) begin
        if (gap_in > 0) gap_in <= gap_in - 1;
        else begin
          in_data <= request_q.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: random stall, compare each result beat
  int gap_out = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got++;
        if (result_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          out_t e;
          e = result_q.pop_front();
          if (out_data.status != e.status) begin
            $error("status expected %0d actual %0d", e.status, out_data.status); errors++;
          end
          if (out_data.start_address != e.start_address) begin
            $error("start_address expected %0d actual %0d", e.start_address,
                   out_data.start_address); errors++;
          end
          if (out_data.free_bytes != e.free_bytes) begin
            $error("free_bytes expected %0d actual %0d", e.free_bytes,
                   out_data.free_bytes); errors++;
          end
          if (e.status == ST_OK) ok_cnt++;
          if (e.status == ST_FULL) full_cnt++;
          if (e.status == ST_NOFIT) nofit_cnt++;
        end
        gap_out <= $urandom_range(0, 19);
        out_stall <= ($urandom_range(0, 2) == 0);
      end else if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  function automatic in_t make_req(logic m, int unsigned ow, int unsigned rq);
    in_t r;
    r.mode = m; r.owner_id = ow[15:0]; r.request_bytes = rq[16:0];
    return r;
  endfunction

  // Mostly well-formed: page-multiple sizes, small owner pool, some noise
  function automatic in_t random_req();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50)
      return make_req(MODE_ALLOC, $urandom_range(1, 40),
                      PAGE * (($urandom_range(0, 3) == 0) ? $urandom_range(1, 256)
                                                          : $urandom_range(1, 8)));
    else if (sel < 90)
      return make_req(MODE_FREE, $urandom_range(1, 40), $urandom_range(0, 131071));
    else if (sel < 95)
      return make_req(MODE_ALLOC, $urandom_range(0, 65535), $urandom_range(0, 131071));
    else
      return make_req(1'($urandom_range(0, 1)), ($urandom_range(0, 1) ? 0 : 65535),
                      $urandom_range(0, 131071));
  endfunction

  task automatic write_policy(logic [1:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_FIT_POLICY[1:0]}; pwdata <= {30'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    policy = v;
  endtask

  task automatic drain();
    while (request_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    logic [1:0] plist[5];
    table_reset();
    policy = POL_FIRST;
    plist = '{POL_FIRST, POL_BEST, POL_WORST, POL_UNUSED, POL_BEST};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed: bad requests, whole memory, edges, missing owner, merges
    request_q.push_back(make_req(MODE_ALLOC, 0, PAGE));
    request_q.push_back(make_req(MODE_ALLOC, 5, 0));
    request_q.push_back(make_req(MODE_ALLOC, 5, 100));
    request_q.push_back(make_req(MODE_ALLOC, 5, 131071));
    request_q.push_back(make_req(MODE_ALLOC, 5, MEM + PAGE));
    request_q.push_back(make_req(MODE_FREE, 0, 0));
    request_q.push_back(make_req(MODE_FREE, 7, 0));
    request_q.push_back(make_req(MODE_ALLOC, 65535, MEM));
    request_q.push_back(make_req(MODE_ALLOC, 2, PAGE));
    request_q.push_back(make_req(MODE_FREE, 65535, 131071));
    request_q.push_back(make_req(MODE_ALLOC, 1, PAGE));
    request_q.push_back(make_req(MODE_ALLOC, 2, 2 * PAGE));
    request_q.push_back(make_req(MODE_ALLOC, 3, PAGE));
    request_q.push_back(make_req(MODE_ALLOC, 4, MEM - 4 * PAGE));
    request_q.push_back(make_req(MODE_ALLOC, 9, PAGE));
    request_q.push_back(make_req(MODE_FREE, 2, 0));
    request_q.push_back(make_req(MODE_FREE, 1, 0));
    request_q.push_back(make_req(MODE_FREE, 4, 0));
    request_q.push_back(make_req(MODE_FREE, 3, 0));
    request_q.push_back(make_req(MODE_ALLOC, 43690, 21845 & ~(PAGE - 1)));
    request_q.push_back(make_req(MODE_FREE, 21845, 0));
    request_q.push_back(make_req(MODE_FREE, 43690, 0));
    drain();

    // Fill the table with single pages to reach the full case
    for (int i = 0; i < 70; i++) request_q.push_back(make_req(MODE_ALLOC, 100 + i, PAGE));
    for (int i = 0; i < 70; i += 2) request_q.push_back(make_req(MODE_FREE, 100 + i, 0));
    drain();

    // Random phases under each policy
    foreach (plist[p]) begin
      write_policy(plist[p]);
      for (int i = 0; i < 360; i++) request_q.push_back(random_req());
      drain();
    end

    $display("Covered %0d requests: %0d ok, %0d no-fit, %0d table-full, all fit policies.",
             sent, ok_cnt, nofit_cnt, full_cnt);
    if (errors == 0 && result_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
